// ===== rtl/tse_pkg.sv =====
// Shared constants for the topological sort engine.
// No dependencies; used by tse_degree_ram and topological_sort_engine.
package tse_pkg;

  localparam int NODE_W = 7;
  localparam int DEG_W  = 9;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_SORT     = 1'b1;

endpackage

// ===== rtl/tse_degree_ram.sv =====
// In-degree store: one synchronous memory, per-entry valid bits, write forwarding.
// Depends on tse_pkg for the degree width.
module tse_degree_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic [AW-1:0]              rd_addr,
  output logic [tse_pkg::DEG_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [tse_pkg::DEG_W-1:0]  wr_data
);

  logic [tse_pkg::DEG_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid;
  logic [tse_pkg::DEG_W-1:0] mem_q;
  logic                      valid_q;
  logic [AW-1:0]             raddr_q;
  logic                      lw_v;
  logic [AW-1:0]             lw_addr;
  logic [tse_pkg::DEG_W-1:0] lw_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q   <= mem[rd_addr];
    raddr_q <= rd_addr;
    lw_addr <= wr_addr;
    lw_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      valid_q <= 1'b0;
      lw_v    <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
      lw_v    <= wr_en;
    end
  end

  // forward the write made at the same edge as the read
  always_comb begin
    if (lw_v && (lw_addr == raddr_q)) begin
      rd_data = lw_data;
    end else if (valid_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ===== rtl/topological_sort_engine.sv =====
// Top level of the topological sort engine: edge store, ready queue, sort sequencer.
// Depends on tse_pkg and tse_degree_ram.
//
// channel   direction  handshake                 payload
// command   in         start & !busy             cmd, src_node, dst_node
// result    out        result_valid (1 cycle)    node_id, has_node, last, complete,
//                                                edge_overflow
// config    in         cfg_valid & cfg_ready     cfg_data (node_count)
//
// Add-edge commands are taken one per cycle; busy stays low for them.
// A sort holds busy while it scans the n nodes in use and then, for each node it
// emits, walks every stored edge once.
// In-degree entries carry valid bits, so reset and the clear after a sort need not walk the memory.
// Results cannot be stalled; each sits on the ports for one cycle with result_valid.
module topological_sort_engine #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [tse_pkg::NODE_W-1:0]  src_node,
  input  logic [tse_pkg::NODE_W-1:0]  dst_node,
  output logic                        result_valid,
  output logic [tse_pkg::NODE_W-1:0]  node_id,
  output logic                        has_node,
  output logic                        last,
  output logic                        complete,
  output logic                        edge_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tse_pkg::NODE_W-1:0]  cfg_data
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int NODE_W = tse_pkg::NODE_W;
  localparam int DEG_W  = tse_pkg::DEG_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_POP    = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] n_eff;

  logic [2*NW-1:0]   edge_mem [MAX_EDGES];
  logic [2*NW-1:0]   edge_q;
  logic [ETW-1:0]    edge_total;
  logic              ovf_seen;

  logic [NW-1:0]     queue_mem [MAX_NODES];
  logic [NW-1:0]     cur;
  logic [CW-1:0]     head;
  logic [CW-1:0]     tail;

  logic [CW-1:0]     scan_idx;
  logic              s1_v;
  logic [NW-1:0]     s1_idx;
  logic [ETW-1:0]    edge_idx;
  logic              w1_v;
  logic              w2_v;
  logic [NW-1:0]     w2_dst;
  logic [CW-1:0]     emitted;
  logic [CW-1:0]     emitted_next;

  logic              a_v;
  logic [NW-1:0]     a_dst;

  logic [NODE_W-1:0] src_m1;
  logic [NODE_W-1:0] dst_m1;
  logic              accept;
  logic              add_ok;
  logic [NW-1:0]     w1_src;
  logic [NW-1:0]     w1_dst;
  logic              w1_hit;
  logic              queue_empty;
  logic              clear;

  logic [NW-1:0]     rd_addr;
  logic [DEG_W-1:0]  deg_rd;
  logic              wr_en;
  logic [NW-1:0]     wr_addr;
  logic [DEG_W-1:0]  wr_data;
  logic              enq;
  logic [NW-1:0]     enq_idx;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign n_eff = (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count;

  assign src_m1 = src_node - NODE_W'(1);
  assign dst_m1 = dst_node - NODE_W'(1);
  assign add_ok = (src_node != '0) && (src_node <= n_eff)
               && (dst_node != '0) && (dst_node <= n_eff);

  assign w1_src = edge_q[2*NW-1:NW];
  assign w1_dst = edge_q[NW-1:0];
  assign w1_hit = w1_v && (w1_src == cur) && (NODE_W'(w1_dst) < n_eff);

  assign queue_empty  = (head == tail);
  assign emitted_next = emitted + CW'(1);
  assign clear        = (state == S_FINISH) || ((state == S_EMIT) && queue_empty);

  always_comb begin
    unique case (state)
      S_SCAN:          rd_addr = scan_idx[NW-1:0];
      S_WALK, S_DRAIN: rd_addr = w1_dst;
      default:         rd_addr = dst_m1[NW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_dst;
    wr_data = deg_rd + DEG_W'(1);
    enq     = 1'b0;
    enq_idx = s1_idx;
    if (a_v) begin
      wr_en = 1'b1;
    end else if (w2_v && (deg_rd != '0)) begin
      wr_en   = 1'b1;
      wr_addr = w2_dst;
      wr_data = deg_rd - DEG_W'(1);
      enq     = (deg_rd == DEG_W'(1));
      enq_idx = w2_dst;
    end else if (s1_v && (deg_rd == '0)) begin
      enq = 1'b1;
    end
  end

  tse_degree_ram #(
    .DEPTH (MAX_NODES)
  ) u_degree (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .rd_addr (rd_addr),
    .rd_data (deg_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // edge and queue memories
  always_ff @(posedge clk) begin
    if (accept && (cmd == tse_pkg::CMD_ADD_EDGE) && add_ok
        && (edge_total != ETW'(MAX_EDGES))) begin
      edge_mem[edge_total[EW-1:0]] <= {src_m1[NW-1:0], dst_m1[NW-1:0]};
    end
    edge_q <= edge_mem[edge_idx[EW-1:0]];
    if (enq && (tail != CW'(MAX_NODES))) begin
      queue_mem[tail[NW-1:0]] <= enq_idx;
    end
    if (state == S_POP) begin
      cur <= queue_mem[head[NW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    a_dst  <= dst_m1[NW-1:0];
    s1_idx <= scan_idx[NW-1:0];
    w2_dst <= w1_dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tse_pkg::NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      edge_total   <= '0;
      ovf_seen     <= 1'b0;
      head         <= '0;
      tail         <= '0;
      scan_idx     <= '0;
      edge_idx     <= '0;
      emitted      <= '0;
      a_v          <= 1'b0;
      s1_v         <= 1'b0;
      w1_v         <= 1'b0;
      w2_v         <= 1'b0;
      result_valid <= 1'b0;
      node_id      <= '0;
      has_node     <= 1'b0;
      last         <= 1'b0;
      complete     <= 1'b0;
      edge_overflow <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      a_v          <= 1'b0;
      s1_v         <= 1'b0;
      w1_v         <= 1'b0;
      w2_v         <= w1_hit;
      if (enq && (tail != CW'(MAX_NODES))) begin
        tail <= tail + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == tse_pkg::CMD_SORT) begin
              state    <= S_SCAN;
              head     <= '0;
              tail     <= '0;
              scan_idx <= '0;
              emitted  <= '0;
            end else if (add_ok) begin
              if (edge_total == ETW'(MAX_EDGES)) begin
                ovf_seen <= 1'b1;
              end else begin
                edge_total <= edge_total + ETW'(1);
                a_v        <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          if (NODE_W'(scan_idx) < n_eff) begin
            s1_v     <= 1'b1;
            scan_idx <= scan_idx + CW'(1);
          end else if (!s1_v) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (!queue_empty) begin
            head     <= head + CW'(1);
            edge_idx <= '0;
            state    <= S_WALK;
          end else begin
            state <= S_FINISH;
          end
        end
        S_WALK: begin
          if (edge_idx < edge_total) begin
            w1_v     <= 1'b1;
            edge_idx <= edge_idx + ETW'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!w1_v && !w2_v) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_valid  <= 1'b1;
          node_id       <= NODE_W'(cur) + NODE_W'(1);
          has_node      <= 1'b1;
          last          <= queue_empty;
          complete      <= queue_empty && (NODE_W'(emitted_next) == n_eff);
          edge_overflow <= queue_empty && ovf_seen;
          emitted       <= emitted_next;
          if (queue_empty) begin
            edge_total <= '0;
            ovf_seen   <= 1'b0;
            state      <= S_IDLE;
          end else begin
            state <= S_POP;
          end
        end
        S_FINISH: begin
          result_valid  <= 1'b1;
          node_id       <= '0;
          has_node      <= 1'b0;
          last          <= 1'b1;
          complete      <= (NODE_W'(emitted) == n_eff);
          edge_overflow <= ovf_seen;
          edge_total    <= '0;
          ovf_seen      <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
